/* design/catdc_pkg.sv */
package catdc_pkg;

  // Input item kinds
  localparam logic [1:0] FUNC_HOST  = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_STATE = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FWD   = 2'd1;
  localparam logic [1:0] KIND_TELEM = 2'd2;

  // Timeout register reset value, in ticks
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOK,
    ST_MISS,
    ST_SEND
  } state_e;

  // One stored command result
  typedef struct packed {
    logic [31:0] key;
    logic        failed;
    logic        actual;
  } cache_ent_t;

  // One result beat waiting to be sent
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        failed;
    logic        state;
  } beat_t;

endpackage

/* design/command_ack_tracker_with_dedup_cache.sv */
// Tracks one outstanding on/off actuator command and answers repeated host commands from a
// small round-robin result cache held in a one-read-port RAM with valid bits in flip-flops
// (no clearing pass after reset). Every item is first decoded. A host command for this
// device with a nonzero id then walks the cache with a single 32-bit key comparator, one
// entry per cycle, until it hits or has checked every entry (on a miss the same comparator
// then checks the pending id). Each result then goes into the output register, at most two
// results per item, held back while the output is stalled. Acks, state packets and ticks
// skip the walk. Input stall stays high until the last result of the current item has
// gone into the output register, and the next item is taken in the following cycle at the
// earliest.
// The timeout register is ready for a write only while the block is idle.
module command_ack_tracker_with_dedup_cache #(
  parameter int CACHE_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // Input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] command_id_i,
  input  logic        for_this_device_i,
  input  logic        op_is_set_i,
  input  logic        wanted_value_i,
  input  logic [1:0]  acked_request_i,
  input  logic        reported_actual_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [31:0] ack_id_o,
  output logic        ack_failed_o,
  output logic        actuator_state_o,
  output logic        last_result_o
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);
  localparam int ENT_W = $bits(catdc_pkg::cache_ent_t);

  catdc_pkg::state_e state_q, state_d;

  // Latched input item
  logic [1:0]  func_q, func_d;
  logic [31:0] id_q, id_d;
  logic        mine_q, mine_d;
  logic        set_q, set_d;
  logic        want_q, want_d;
  logic [1:0]  req_q, req_d;
  logic        rep_q, rep_d;

  // Cache walk
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [IDX_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [CACHE_ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]         ins_ptr_q, ins_ptr_d;

  // Pending command and actuator state
  logic        pend_q, pend_d;
  logic [31:0] pend_key_q, pend_key_d;
  logic        pend_want_q, pend_want_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] elapsed_inc;
  logic        actual_q, actual_d;
  logic [15:0] timeout_q;

  // Result beats
  catdc_pkg::beat_t beat_q [2];
  catdc_pkg::beat_t beat_d [2];
  logic             two_q, two_d;
  logic             sel_q, sel_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic [31:0] out_id_q;
  logic        out_failed_q;
  logic        out_state_q;
  logic        out_last_q;
  logic        out_free;
  logic        out_load;
  logic        send_last;

  // Cache RAM and shared key comparator
  logic                  ram_we;
  catdc_pkg::cache_ent_t ram_wdata;
  logic [ENT_W-1:0]      ram_rdata;
  catdc_pkg::cache_ent_t rd_ent;
  logic [31:0]           cmp_key;
  logic                  key_eq;

  // Result to remember
  logic        rem_en;
  logic [31:0] rem_key;
  logic        rem_failed;
  logic        rem_actual;

  catdc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ins_ptr_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_ent  = catdc_pkg::cache_ent_t'(ram_rdata);
  assign cmp_key = (state_q == catdc_pkg::ST_MISS) ? pend_key_q : rd_ent.key;
  assign key_eq  = (cmp_key == id_q);

  assign elapsed_inc = (elapsed_q == catdc_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign send_last = !two_q || sel_q;
  assign out_load  = (state_q == catdc_pkg::ST_SEND) && out_free;

  assign in_stall_o  = (state_q != catdc_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == catdc_pkg::ST_IDLE);

  // Sequence one item: decode, walk the cache, stage results, send them
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    mine_d      = mine_q;
    set_d       = set_q;
    want_d      = want_q;
    req_d       = req_q;
    rep_d       = rep_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    valid_d     = valid_q;
    ins_ptr_d   = ins_ptr_q;
    pend_d      = pend_q;
    pend_key_d  = pend_key_q;
    pend_want_d = pend_want_q;
    elapsed_d   = elapsed_q;
    actual_d    = actual_q;
    beat_d      = beat_q;
    two_d       = two_q;
    sel_d       = sel_q;
    rem_en      = 1'b0;
    rem_key     = id_q;
    rem_failed  = 1'b1;
    rem_actual  = actual_q;

    case (state_q)
      catdc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          id_d    = command_id_i;
          mine_d  = for_this_device_i;
          set_d   = op_is_set_i;
          want_d  = wanted_value_i;
          req_d   = acked_request_i;
          rep_d   = reported_actual_i;
          sel_d   = 1'b0;
          two_d   = 1'b0;
          state_d = catdc_pkg::ST_DECODE;
        end
      end

      catdc_pkg::ST_DECODE: begin
        case (func_q)
          catdc_pkg::FUNC_HOST: begin
            if (!mine_q || (id_q == 32'd0)) begin
              state_d = catdc_pkg::ST_IDLE;
            end else begin
              idx_d     = '0;
              cmp_vld_d = 1'b0;
              state_d   = catdc_pkg::ST_LOOK;
            end
          end
          catdc_pkg::FUNC_STATE: begin
            actual_d  = rep_q;
            beat_d[0] = '{kind: catdc_pkg::KIND_TELEM, id: 32'd0, failed: 1'b0, state: rep_q};
            state_d   = catdc_pkg::ST_SEND;
          end
          catdc_pkg::FUNC_ACK: begin
            actual_d  = rep_q;
            beat_d[0] = '{kind: catdc_pkg::KIND_TELEM, id: 32'd0, failed: 1'b0, state: rep_q};
            // Resolve the pending command when the echo matches its request
            if (pend_q && (req_q == {1'b0, pend_want_q})) begin
              two_d      = 1'b1;
              beat_d[1]  = '{kind: catdc_pkg::KIND_ACK, id: pend_key_q,
                             failed: (rep_q != pend_want_q), state: rep_q};
              rem_en     = 1'b1;
              rem_key    = pend_key_q;
              rem_failed = (rep_q != pend_want_q);
              rem_actual = rep_q;
              pend_d     = 1'b0;
              pend_key_d = 32'd0;
              elapsed_d  = 16'd0;
            end
            state_d = catdc_pkg::ST_SEND;
          end
          catdc_pkg::FUNC_TICK: begin
            if (!pend_q) begin
              state_d = catdc_pkg::ST_IDLE;
            end else if (elapsed_inc >= timeout_q) begin
              // Time out the pending command as failed
              beat_d[0]  = '{kind: catdc_pkg::KIND_ACK, id: pend_key_q,
                             failed: 1'b1, state: actual_q};
              rem_en     = 1'b1;
              rem_key    = pend_key_q;
              rem_failed = 1'b1;
              rem_actual = actual_q;
              pend_d     = 1'b0;
              pend_key_d = 32'd0;
              elapsed_d  = 16'd0;
              state_d    = catdc_pkg::ST_SEND;
            end else begin
              elapsed_d = elapsed_inc;
              state_d   = catdc_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = catdc_pkg::ST_IDLE;
          end
        endcase
      end

      catdc_pkg::ST_LOOK: begin
        // Issue the next read, compare the entry read last cycle
        idx_d     = idx_q + IDX_W'(1);
        cmp_idx_d = idx_q;
        cmp_vld_d = 1'b1;
        if (cmp_vld_q) begin
          if (valid_q[cmp_idx_q] && key_eq) begin
            beat_d[0] = '{kind: catdc_pkg::KIND_ACK, id: id_q,
                          failed: rd_ent.failed, state: rd_ent.actual};
            state_d   = catdc_pkg::ST_SEND;
          end else if (cmp_idx_q == IDX_LAST) begin
            state_d = catdc_pkg::ST_MISS;
          end
        end
      end

      catdc_pkg::ST_MISS: begin
        if (pend_q && key_eq) begin
          // Drop a repeat of the pending command
          state_d = catdc_pkg::ST_IDLE;
        end else if (!set_q) begin
          beat_d[0]  = '{kind: catdc_pkg::KIND_ACK, id: id_q, failed: 1'b1, state: actual_q};
          rem_en     = 1'b1;
          rem_key    = id_q;
          rem_failed = 1'b1;
          rem_actual = actual_q;
          state_d    = catdc_pkg::ST_SEND;
        end else if (pend_q) begin
          // Drop while another command is outstanding
          state_d = catdc_pkg::ST_IDLE;
        end else begin
          pend_d      = 1'b1;
          pend_key_d  = id_q;
          pend_want_d = want_q;
          elapsed_d   = 16'd0;
          beat_d[0]   = '{kind: catdc_pkg::KIND_FWD, id: id_q, failed: 1'b0, state: want_q};
          state_d     = catdc_pkg::ST_SEND;
        end
      end

      catdc_pkg::ST_SEND: begin
        if (out_free) begin
          if (send_last) begin
            state_d = catdc_pkg::ST_IDLE;
          end else begin
            sel_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = catdc_pkg::ST_IDLE;
      end
    endcase

    // Store a result at the round-robin slot
    ram_we    = rem_en;
    ram_wdata = '{key: rem_key, failed: rem_failed, actual: rem_actual};
    if (rem_en) begin
      valid_d[ins_ptr_q] = 1'b1;
      ins_ptr_d          = (ins_ptr_q == IDX_LAST) ? '0 : ins_ptr_q + IDX_W'(1);
    end
  end

  // Hold the output transfer until taken, load the next beat when free
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= catdc_pkg::ST_IDLE;
      cmp_vld_q   <= 1'b0;
      valid_q     <= '0;
      ins_ptr_q   <= '0;
      pend_q      <= 1'b0;
      pend_key_q  <= 32'd0;
      pend_want_q <= 1'b0;
      elapsed_q   <= 16'd0;
      actual_q    <= 1'b0;
      timeout_q   <= catdc_pkg::TIMEOUT_RST;
      two_q       <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      valid_q     <= valid_d;
      ins_ptr_q   <= ins_ptr_d;
      pend_q      <= pend_d;
      pend_key_q  <= pend_key_d;
      pend_want_q <= pend_want_d;
      elapsed_q   <= elapsed_d;
      actual_q    <= actual_d;
      two_q       <= two_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    id_q      <= id_d;
    mine_q    <= mine_d;
    set_q     <= set_d;
    want_q    <= want_d;
    req_q     <= req_d;
    rep_q     <= rep_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    beat_q    <= beat_d;
    if (out_load) begin
      out_kind_q   <= beat_q[sel_q].kind;
      out_id_q     <= beat_q[sel_q].id;
      out_failed_q <= beat_q[sel_q].failed;
      out_state_q  <= beat_q[sel_q].state;
      out_last_q   <= send_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign ack_id_o         = out_id_q;
  assign ack_failed_o     = out_failed_q;
  assign actuator_state_o = out_state_q;
  assign last_result_o    = out_last_q;

  // A new result only comes from the send state
  a_out_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == catdc_pkg::ST_SEND))
    else $error("output transfer raised outside the send state");

  // A pending command is only released together with a cache write
  a_release_cached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> $past(ram_we))
    else $error("pending command released without storing its result");

  // The insert pointer stays inside the cache
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ptr_q <= IDX_LAST)
    else $error("insert pointer out of range");

  // The second beat is only sent for a two-result item
  a_second_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == catdc_pkg::ST_SEND && sel_q) |-> two_q)
    else $error("second result beat without a second result");

  // A lookup never goes straight on to decoding a new item
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == catdc_pkg::ST_LOOK) |=> (state_q != catdc_pkg::ST_DECODE))
    else $error("lookup left without a decision");

endmodule

/* design/catdc_ram.sv */
module catdc_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
